### sv/mhpq_pkg.sv
// Shared types, constants and status codes of the max-heap priority queue.
package mhpq_pkg;

  // Heap size and derived widths
  localparam int CAPACITY = 15;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int KEY_W    = 32;
  localparam int OCC_W    = 4;
  localparam int STAT_W   = 2;

  // Operation codes carried by in_mode
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_TOP,
    ST_DN_LAST,
    ST_DN_TAKE,
    ST_DN_RDL,
    ST_DN_RDR,
    ST_DN_CMP,
    ST_DONE
  } state_t;

  // One finished result, handed from the sequencer to the output stage
  typedef struct packed {
    logic signed [KEY_W-1:0] max_key;
    logic [STAT_W-1:0]       status;
    logic [OCC_W-1:0]        occupancy;
  } res_t;

endpackage

### sv/max_heap_priority_queue_core.sv
// Top level of the max-heap priority queue: sequencer, heap RAM and output register.
//
//  channel | ports                                       | direction
//  --------+---------------------------------------------+----------
//  input   | in_valid, in_ready, in_mode, in_key         | in
//  result  | out_valid, out_ready, out_max_key,          | out
//          | out_status, out_occupancy                   |
//
// An insert climbs level by level from the new leaf until it reaches the root or a parent
// stops it; a delete descends from the root until it reaches a leaf or a child stops it.
// A failed insert or delete goes straight to its result. One item at a time.
// Reset empties the heap at once; no clearing pass runs over the RAM.
// A new item is taken while the previous result waits; a full output stalls the hand-on.
module max_heap_priority_queue_core
  import mhpq_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_mode,
  input  logic signed [KEY_W-1:0] in_key,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [KEY_W-1:0] out_max_key,
  output logic [STAT_W-1:0]       out_status,
  output logic [OCC_W-1:0]        out_occupancy
);

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             ram_wr_en;
  logic [CNT_W-1:0] ram_wr_addr;
  logic [KEY_W-1:0] ram_wr_data;
  logic             ram_rd_en;
  logic [CNT_W-1:0] ram_rd_addr;
  logic [KEY_W-1:0] ram_rd_data;
  logic             out_valid_r;
  res_t             out_res_r;

  mhpq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_mode     (in_mode),
    .in_key      (in_key),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  mhpq_ram #(
    .DEPTH  (CAPACITY + 1),
    .DATA_W (KEY_W),
    .ADDR_W (CNT_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Free the output slot when empty or being taken
  assign res_ready = !out_valid_r || out_ready;

  // Hold the result until its transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_max_key   = out_res_r.max_key;
  assign out_status    = out_res_r.status;
  assign out_occupancy = out_res_r.occupancy;

endmodule

### sv/mhpq_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module mhpq_ram #(
  parameter int DEPTH  = 16,
  parameter int DATA_W = 32,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read port, registered read data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/mhpq_ctrl.sv
// Heap sequencer: sift-up and sift-down walks over the heap RAM, one level per pass.
module mhpq_ctrl
  import mhpq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_mode,
  input  logic [KEY_W-1:0]  in_key,
  output logic              res_valid,
  input  logic              res_ready,
  output res_t              res,
  output logic              ram_wr_en,
  output logic [CNT_W-1:0]  ram_wr_addr,
  output logic [KEY_W-1:0]  ram_wr_data,
  output logic              ram_rd_en,
  output logic [CNT_W-1:0]  ram_rd_addr,
  input  logic [KEY_W-1:0]  ram_rd_data
);

  state_t                  state_r, state_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        pos_r, pos_nxt;
  logic signed [KEY_W-1:0] key_r, key_nxt;
  logic signed [KEY_W-1:0] left_r, left_nxt;
  logic signed [KEY_W-1:0] max_r, max_nxt;
  logic [STAT_W-1:0]       status_r, status_nxt;

  logic                    in_xfer;
  logic [CNT_W:0]          child_l;
  logic [CNT_W:0]          child_r;
  logic [CNT_W:0]          count_ext;
  logic                    has_right;
  logic signed [KEY_W-1:0] rd_key;
  logic                    pick_right;
  logic signed [KEY_W-1:0] big_key;
  logic [CNT_W:0]          big_idx;
  logic                    heap_full;
  logic                    heap_empty;

  assign in_xfer    = in_valid && in_ready;
  assign child_l    = {pos_r, 1'b0};
  assign child_r    = {pos_r, 1'b1};
  assign count_ext  = {1'b0, count_r};
  assign has_right  = child_l < count_ext;
  assign rd_key     = $signed(ram_rd_data);
  assign pick_right = has_right && (rd_key > left_r);
  assign big_key    = pick_right ? rd_key : left_r;
  assign big_idx    = pick_right ? child_r : child_l;
  assign heap_full  = count_r == CNT_W'(CAPACITY);
  assign heap_empty = count_r == '0;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_mode == MODE_INSERT) begin
            state_nxt = heap_full ? ST_DONE : ST_UP_RD;
          end else begin
            state_nxt = heap_empty ? ST_DONE : ST_DN_TOP;
          end
        end
      end
      ST_UP_RD:   state_nxt = (pos_r == CNT_W'(1)) ? ST_DONE : ST_UP_CMP;
      ST_UP_CMP:  state_nxt = (rd_key < key_r) ? ST_UP_RD : ST_DONE;
      ST_DN_TOP:  state_nxt = ST_DN_LAST;
      ST_DN_LAST: state_nxt = ST_DN_TAKE;
      ST_DN_TAKE: state_nxt = ST_DN_RDL;
      ST_DN_RDL:  state_nxt = (child_l > count_ext) ? ST_DONE : ST_DN_RDR;
      ST_DN_RDR:  state_nxt = ST_DN_CMP;
      ST_DN_CMP:  state_nxt = (key_r > big_key) ? ST_DONE : ST_DN_RDL;
      ST_DONE:    state_nxt = res_ready ? ST_IDLE : ST_DONE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, RAM strobes and handshake outputs
  always_comb begin
    count_nxt   = count_r;
    pos_nxt     = pos_r;
    key_nxt     = key_r;
    left_nxt    = left_r;
    max_nxt     = max_r;
    status_nxt  = status_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = pos_r;
    ram_wr_data = key_r;
    ram_rd_en   = 1'b0;
    ram_rd_addr = pos_r;
    in_ready    = 1'b0;
    res_valid   = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_xfer) begin
          max_nxt    = '0;
          status_nxt = STAT_OK;
          key_nxt    = $signed(in_key);
          if (in_mode == MODE_INSERT) begin
            if (heap_full) begin
              status_nxt = STAT_FULL;
            end else begin
              count_nxt = count_r + CNT_W'(1);
              pos_nxt   = count_r + CNT_W'(1);
            end
          end else if (heap_empty) begin
            status_nxt = STAT_EMPTY;
          end
        end
      end
      // Fetch the parent, or drop the key at the root
      ST_UP_RD: begin
        if (pos_r == CNT_W'(1)) begin
          ram_wr_en = 1'b1;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = pos_r >> 1;
        end
      end
      // Move a smaller parent down into the hole, else settle the key
      ST_UP_CMP: begin
        ram_wr_en = 1'b1;
        if (rd_key < key_r) begin
          ram_wr_data = ram_rd_data;
          pos_nxt     = pos_r >> 1;
        end
      end
      ST_DN_TOP: begin
        ram_rd_en   = 1'b1;
        ram_rd_addr = CNT_W'(1);
      end
      // Capture the root as the result, fetch the last entry
      ST_DN_LAST: begin
        max_nxt     = rd_key;
        ram_rd_en   = 1'b1;
        ram_rd_addr = count_r;
      end
      ST_DN_TAKE: begin
        key_nxt   = rd_key;
        count_nxt = count_r - CNT_W'(1);
        pos_nxt   = CNT_W'(1);
      end
      // Fetch the left child, or settle the key at a leaf
      ST_DN_RDL: begin
        if (child_l > count_ext) begin
          ram_wr_en = 1'b1;
        end else begin
          ram_rd_en   = 1'b1;
          ram_rd_addr = child_l[CNT_W-1:0];
        end
      end
      ST_DN_RDR: begin
        left_nxt    = rd_key;
        ram_rd_en   = has_right;
        ram_rd_addr = child_r[CNT_W-1:0];
      end
      // Lift the larger child into the hole unless the key is strictly greater
      ST_DN_CMP: begin
        ram_wr_en = 1'b1;
        if (!(key_r > big_key)) begin
          ram_wr_data = big_key;
          pos_nxt     = big_idx[CNT_W-1:0];
        end
      end
      ST_DONE: begin
        res_valid = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  assign res.max_key   = max_r;
  assign res.status    = status_r;
  assign res.occupancy = OCC_W'(count_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    pos_r    <= pos_nxt;
    key_r    <= key_nxt;
    left_r   <= left_nxt;
    max_r    <= max_nxt;
    status_r <= status_nxt;
  end

endmodule

### sv/mhpq_checker.sv
// Port-level checker of the max-heap priority queue, bound to the top level.
module mhpq_checker
  import mhpq_pkg::*;
(
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [KEY_W-1:0] out_max_key,
  input logic [STAT_W-1:0]       out_status,
  input logic [OCC_W-1:0]        out_occupancy
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_max_key) && $stable(out_status))
    else $error("result changed while stalled");

  // One item at a time: no transfer in the cycle after one
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while previous item in work");

  // Failed operations return a zero key
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != STAT_OK |-> out_max_key == '0)
    else $error("failed operation returned a key");

  // Empty delete reports no keys held
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_EMPTY |-> out_occupancy == '0)
    else $error("empty status with keys held");

  // Full insert reports a full heap
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == STAT_FULL |-> out_occupancy == OCC_W'(CAPACITY))
    else $error("full status without a full heap");

endmodule

bind max_heap_priority_queue_core mhpq_checker u_mhpq_checker (.*);

### verif/max_heap_priority_queue_core_tb.sv
// Self-checking testbench of the max-heap priority queue core: random and directed heap traffic.
`timescale 1ns / 1ps

module max_heap_priority_queue_core_tb;
  import mhpq_pkg::*;

  localparam int RANDOM_OPS    = 1350;
  localparam int QUIET_LIMIT   = 1000;
  localparam int TAIL_OPS      = 80;
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    logic                    mode;
    logic signed [KEY_W-1:0] key;
    bit                      drain_first;
  } heap_op_t;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic                    in_mode = MODE_INSERT;
  logic signed [KEY_W-1:0] in_key = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic signed [KEY_W-1:0] out_max_key;
  logic [STAT_W-1:0]       out_status;
  logic [OCC_W-1:0]        out_occupancy;

  heap_op_t pending_ops[$];
  res_t     expected_results[$];
  heap_op_t next_op;
  res_t     want;
  int       mismatches = 0;
  int       gap_left = 0;
  int       stall_left = 0;
  int       quiet_cycles = 0;
  bit       in_idle_on = 1'b1;
  bit       out_stall_on = 1'b1;

  // Shadow heap, indexed from 1 like the block's store
  logic signed [KEY_W-1:0] shadow_heap [1:CAPACITY];
  int unsigned             shadow_count = 0;

  max_heap_priority_queue_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_key        (in_key),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_max_key   (out_max_key),
    .out_status    (out_status),
    .out_occupancy (out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one operation to the shadow heap and return the result it should produce
  function automatic res_t heap_apply(logic mode, logic signed [KEY_W-1:0] key);
    res_t                    r;
    int unsigned             pos;
    int unsigned             parent;
    int unsigned             child;
    logic signed [KEY_W-1:0] tmp;
    r.max_key = '0;
    r.status  = STAT_OK;
    if (mode == MODE_INSERT) begin
      if (shadow_count >= CAPACITY) begin
        r.status = STAT_FULL;
      end else begin
        // climb past strictly smaller parents, stop at the root
        shadow_count++;
        pos = shadow_count;
        while (pos > 1 && shadow_heap[pos / 2] < key) begin
          shadow_heap[pos] = shadow_heap[pos / 2];
          pos = pos / 2;
        end
        shadow_heap[pos] = key;
      end
    end else begin
      if (shadow_count == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.max_key = shadow_heap[1];
        shadow_heap[1] = shadow_heap[shadow_count];
        shadow_count--;
        parent = 1;
        child  = 2;
        // sift down; left child wins a tie, equal parent still swaps
        while (child <= shadow_count) begin
          if (child < shadow_count && shadow_heap[child + 1] > shadow_heap[child])
            child++;
          if (shadow_heap[parent] > shadow_heap[child])
            break;
          tmp                 = shadow_heap[parent];
          shadow_heap[parent] = shadow_heap[child];
          shadow_heap[child]  = tmp;
          parent              = child;
          child               = child * 2;
        end
      end
    end
    r.occupancy = shadow_count[OCC_W-1:0];
    return r;
  endfunction

  function automatic logic signed [KEY_W-1:0] pick_key();
    logic signed [KEY_W-1:0] k;
    case ($urandom_range(0, 7))
      0, 1, 2: k = $urandom;
      3, 4:    k = $signed(32'($urandom_range(0, 8))) - 32'sd4;
      5: begin
        case ($urandom_range(0, 3))
          0:       k = 32'sh7FFFFFFF;
          1:       k = 32'sh80000000;
          2:       k = '0;
          default: k = -32'sd1;
        endcase
      end
      default: k = $signed(32'($urandom_range(0, 1000)));
    endcase
    return k;
  endfunction

  task automatic add_op(logic mode, logic signed [KEY_W-1:0] key, bit drain_first);
    heap_op_t op;
    op.mode        = mode;
    op.key         = key;
    op.drain_first = drain_first;
    pending_ops.push_back(op);
  endtask

  // Driver: predict on each input transfer, then present the next pending item
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_mode  <= MODE_INSERT;
      in_key   <= '0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(heap_apply(in_mode, in_key));
        if ($urandom_range(0, 39) == 0)
          in_idle_on = !in_idle_on;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ops.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_ops[0].drain_first && expected_results.size() != 0) begin
          in_valid <= 1'b0;
        end else if (in_idle_on && pending_ops.size() > TAIL_OPS &&
                     $urandom_range(0, 3) == 0) begin
          gap_left = $urandom_range(1, 7) - 1;
          in_valid <= 1'b0;
        end else begin
          next_op = pending_ops.pop_front();
          in_valid <= 1'b1;
          in_mode  <= next_op.mode;
          in_key   <= next_op.key;
        end
      end
    end
  end

  // Monitor: check each result transfer, then decide whether to stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result: max_key %0d status %0d occupancy %0d",
                   $time, out_max_key, out_status, out_occupancy);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_max_key !== want.max_key) begin
            $display("%0t: max_key expected %0d actual %0d", $time, want.max_key, out_max_key);
            mismatches++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            mismatches++;
          end
          if (out_occupancy !== want.occupancy) begin
            $display("%0t: occupancy expected %0d actual %0d",
                     $time, want.occupancy, out_occupancy);
            mismatches++;
          end
        end
      end
      if ($urandom_range(0, 59) == 0)
        out_stall_on = !out_stall_on;
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (out_stall_on && pending_ops.size() > TAIL_OPS &&
                   $urandom_range(0, 4) == 0) begin
        stall_left = $urandom_range(1, 7) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run if no transfer happens for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("max_heap_priority_queue_core_tb: done, errors");
        $finish;
      end
    end
  end

  initial begin
    int group;
    int len;
    int kind;
    int k;
    logic mode;
    rst_n = 1'b0;
    for (k = 1; k <= CAPACITY; k++)
      shadow_heap[k] = '0;

    // Directed: delete when empty, fill with extremes and equal keys, insert when full
    add_op(MODE_DELETE, 32'sh5A5A5A5A, 1'b0);
    add_op(MODE_INSERT, 32'sh7FFFFFFF, 1'b0);
    add_op(MODE_INSERT, 32'sh80000000, 1'b0);
    add_op(MODE_INSERT, 32'sh00000000, 1'b0);
    add_op(MODE_INSERT, -32'sd1, 1'b0);
    add_op(MODE_INSERT, 32'sd5, 1'b0);
    add_op(MODE_INSERT, 32'sd5, 1'b0);
    add_op(MODE_INSERT, 32'sd5, 1'b0);
    add_op(MODE_INSERT, -32'sd1, 1'b0);
    add_op(MODE_INSERT, 32'sd100, 1'b0);
    add_op(MODE_INSERT, 32'sh7FFFFFFF, 1'b0);
    add_op(MODE_INSERT, 32'sh80000000, 1'b0);
    add_op(MODE_INSERT, 32'sd1, 1'b0);
    add_op(MODE_INSERT, 32'sd2, 1'b0);
    add_op(MODE_INSERT, 32'sd3, 1'b0);
    add_op(MODE_INSERT, 32'sd4, 1'b0);
    add_op(MODE_INSERT, 32'sd42, 1'b0);
    for (k = 0; k < 6; k++)
      add_op(MODE_DELETE, $urandom, 1'b0);

    // Random: fill, drain and mixed bursts so the heap swings between empty and full
    group = 0;
    while (pending_ops.size() < 23 + RANDOM_OPS) begin
      len  = $urandom_range(5, 20);
      kind = $urandom_range(0, 2);
      for (k = 0; k < len; k++) begin
        case (kind)
          0:       mode = ($urandom_range(0, 7) == 0) ? MODE_DELETE : MODE_INSERT;
          1:       mode = ($urandom_range(0, 7) == 0) ? MODE_INSERT : MODE_DELETE;
          default: mode = $urandom_range(0, 1) ? MODE_DELETE : MODE_INSERT;
        endcase
        add_op(mode, pick_key(), (k == 0) && (group % 20 == 0));
      end
      group++;
    end

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Wait for every item to go in and every result to come back
    @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("max_heap_priority_queue_core_tb: done, clean");
    else
      $display("max_heap_priority_queue_core_tb: done, errors");
    $finish;
  end

endmodule
